>>> design/nzcv_pkg.sv
// Package with the shared types and constants of the NZCV flag and condition unit.
package nzcv_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned WidthW = 7;
  localparam int unsigned CountW = 6;
  localparam int unsigned FlagsW = 4;
  localparam int unsigned CondW = 4;
  localparam int unsigned FuncW = 3;

  // Bit positions inside an NZCV flag nibble.
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD   = 3'd0,
    FUNC_SUB   = 3'd1,
    FUNC_LOGIC = 3'd2,
    FUNC_MUL   = 3'd3,
    FUNC_SHIFT = 3'd4,
    FUNC_COND  = 3'd5
  } func_e;

  typedef enum logic [CondW-1:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14,
    COND_NV = 4'd15
  } cond_e;

  // One input item; func stays a raw code so that unused codes pass through.
  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [DataW-1:0]  operand_a;
    logic [DataW-1:0]  operand_b;
    logic [DataW-1:0]  op_result;
    logic [WidthW-1:0] op_width;
    logic [CountW-1:0] shift_count;
    logic              shifted_out_bit;
    logic [FlagsW-1:0] flags_in;
    logic [CondW-1:0]  cond_code;
  } item_t;

  typedef struct packed {
    logic              cond_true;
    logic [FlagsW-1:0] flags_out;
  } result_t;

endpackage

>>> design/nzcv_flag_calc.sv
// Combinational flag and condition evaluation for one item.
module nzcv_flag_calc (
  input  nzcv_pkg::item_t   item_i,
  output nzcv_pkg::result_t res_o
);
  import nzcv_pkg::*;

  logic [WidthW-1:0] width;
  logic [CountW-1:0] msb;
  logic [DataW-1:0]  mask;
  logic [DataW-1:0]  a_m;
  logic [DataW-1:0]  b_m;
  logic [DataW:0]    sum;
  logic              n_res;
  logic              z_res;
  logic              carry;
  logic              no_borrow;
  logic              v_add;
  logic              v_sub;
  logic              n_in;
  logic              z_in;
  logic              c_in;
  logic              v_in;
  logic              cond_hit;

  // A width of zero or above 64 behaves as the full 64 bits.
  always_comb begin
    if (item_i.op_width == '0 || item_i.op_width > WidthW'(DataW)) begin
      width = WidthW'(DataW);
    end else begin
      width = item_i.op_width;
    end
  end

  assign msb  = CountW'(width - WidthW'(1));
  assign mask = {DataW{1'b1}} >> (WidthW'(DataW) - width);
  assign a_m  = item_i.operand_a & mask;
  assign b_m  = item_i.operand_b & mask;
  assign sum  = {1'b0, a_m} + {1'b0, b_m};

  assign n_res     = item_i.op_result[msb];
  assign z_res     = (item_i.op_result & mask) == '0;
  // The carry out of the top bit of the selected width.
  assign carry     = sum[width];
  assign no_borrow = a_m >= b_m;
  assign v_add     = ~(item_i.operand_a[msb] ^ item_i.operand_b[msb]) &
                     (item_i.operand_a[msb] ^ item_i.op_result[msb]);
  assign v_sub     = (item_i.operand_a[msb] ^ item_i.operand_b[msb]) &
                     (item_i.operand_a[msb] ^ item_i.op_result[msb]);

  assign n_in = item_i.flags_in[FlagN];
  assign z_in = item_i.flags_in[FlagZ];
  assign c_in = item_i.flags_in[FlagC];
  assign v_in = item_i.flags_in[FlagV];

  always_comb begin
    case (item_i.cond_code)
      COND_EQ: cond_hit = z_in;
      COND_NE: cond_hit = !z_in;
      COND_CS: cond_hit = c_in;
      COND_CC: cond_hit = !c_in;
      COND_MI: cond_hit = n_in;
      COND_PL: cond_hit = !n_in;
      COND_VS: cond_hit = v_in;
      COND_VC: cond_hit = !v_in;
      COND_HI: cond_hit = c_in && !z_in;
      COND_LS: cond_hit = !c_in || z_in;
      COND_GE: cond_hit = n_in == v_in;
      COND_LT: cond_hit = n_in != v_in;
      COND_GT: cond_hit = !z_in && (n_in == v_in);
      COND_LE: cond_hit = z_in || (n_in != v_in);
      default: cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    res_o.flags_out = item_i.flags_in;
    res_o.cond_true = 1'b0;
    case (item_i.func)
      FUNC_ADD: begin
        res_o.flags_out = {n_res, z_res, carry, v_add};
      end
      FUNC_SUB: begin
        res_o.flags_out = {n_res, z_res, no_borrow, v_sub};
      end
      FUNC_LOGIC, FUNC_MUL: begin
        res_o.flags_out = {n_res, z_res, 2'b00};
      end
      FUNC_SHIFT: begin
        // A zero count leaves C alone; otherwise C is the last bit shifted out.
        res_o.flags_out = {n_res, z_res,
                           (item_i.shift_count == '0) ? c_in : item_i.shifted_out_bit,
                           v_in};
      end
      FUNC_COND: begin
        res_o.cond_true = cond_hit;
      end
      default: begin
        res_o.flags_out = item_i.flags_in;
      end
    endcase
  end

endmodule

>>> design/nzcv_flag_and_condition_unit.sv
// Top level of the NZCV flag and condition unit: stream ports and two register stages.
//
// Each input transfer carries one flag request and yields exactly one output
// transfer with the new NZCV flags and the condition result. The unit takes a
// new item in every cycle while the output side is ready; the item is held in
// the input register, its result is stored in the result register and offered
// at the output, and it leaves when the output side is ready. One pass
// through the flag logic (a 64-bit carry add and a 64-bit compare) lies between the
// input register and the result register. While a result waits at the output,
// the input register still takes one more item.
module nzcv_flag_and_condition_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // From bit 0: operand_a[63:0], operand_b[127:64], op_result[191:128],
  // op_width[198:192], shift_count[204:199], shifted_out_bit[205],
  // flags_in[209:206], cond_code[213:210], zero fill[215:214].
  input  logic [215:0] s_axis_tdata_i,
  // From bit 0: func[2:0].
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // From bit 0: flags_out[3:0], cond_true[4], zero fill[7:5].
  output logic [7:0]   m_axis_tdata_o
);
  import nzcv_pkg::*;

  logic    in_valid_q;
  logic    in_valid_d;
  item_t   item_q;
  item_t   item_in;
  logic    out_valid_q;
  logic    out_valid_d;
  result_t res_q;
  result_t res_calc;
  logic    out_free;
  logic    in_xfer;
  logic    advance;

  assign item_in = '{
    func:            s_axis_tuser_i,
    operand_a:       s_axis_tdata_i[63:0],
    operand_b:       s_axis_tdata_i[127:64],
    op_result:       s_axis_tdata_i[191:128],
    op_width:        s_axis_tdata_i[198:192],
    shift_count:     s_axis_tdata_i[204:199],
    shifted_out_bit: s_axis_tdata_i[205],
    flags_in:        s_axis_tdata_i[209:206],
    cond_code:       s_axis_tdata_i[213:210]
  };

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_in;
    end
    if (advance) begin
      res_q <= res_calc;
    end
  end

  nzcv_flag_calc u_calc (
    .item_i (item_q),
    .res_o  (res_calc)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, res_q.cond_true, res_q.flags_out};

endmodule

>>> design/nzcv_checker.sv
// Port-level checker of the NZCV flag and condition unit, bound to the top level.
module nzcv_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [7:0]   m_axis_tdata_o
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed while stalled");

  // A ready output side must never hold back the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled although the output is ready");

  // The fill bits above the result fields are always zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:5] == 3'b000)
    else $error("output fill bits not zero");

  // Reset leaves no result pending.
  assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind nzcv_flag_and_condition_unit nzcv_checker u_nzcv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
